// File: rtl/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg
// shared types, codes and helpers of the script byte tokenizer
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int unsigned FIELD_BITS = 16;

  // result kinds
  localparam logic [1:0] KIND_TOKEN      = 2'd0;
  localparam logic [1:0] KIND_END        = 2'd1;
  localparam logic [1:0] KIND_INCOMPLETE = 2'd2;
  localparam logic [1:0] KIND_QUOTE_END  = 2'd3;

  // scan modes
  localparam logic [2:0] MODE_SKIP    = 3'd0;
  localparam logic [2:0] MODE_SLASH   = 3'd1;
  localparam logic [2:0] MODE_COMMENT = 3'd2;
  localparam logic [2:0] MODE_QUOTED  = 3'd3;
  localparam logic [2:0] MODE_BARE    = 3'd4;

  // byte codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

  typedef struct packed {
    logic [1:0]            kind;
    logic [FIELD_BITS-1:0] token_start;
    logic [FIELD_BITS-1:0] token_length;
    logic                  quoted;
    logic [FIELD_BITS-1:0] line_number;
    logic                  last;
  } result_t;

  function automatic logic [FIELD_BITS-1:0] sat_inc(input logic [FIELD_BITS-1:0] v);
    sat_inc = (v == FIELD_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// File: rtl/script_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// script_byte_tokenizer
// splits a script byte stream into tokens, skipping whitespace and comments
// ----------------------------------------------------------------------------
// a result is registered in the result buffer before it is offered
// throughput: one byte per cycle; a byte may give up to two results,
//   queued in a four-entry result buffer that stalls input when nearly full
// reset: synchronous, active low; clears mode, offsets, halt flag and the
//   result buffer, and sets the line count to one
module script_byte_tokenizer
  import sbt_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_ch,
  input  logic                  in_allow_cross_line,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [FIELD_BITS-1:0] out_token_start,
  output logic [FIELD_BITS-1:0] out_token_length,
  output logic                  out_quoted,
  output logic [FIELD_BITS-1:0] out_line_number,
  output logic                  out_last
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  logic [2:0]             mode_r,  mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r,   pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [FIELD_BITS-1:0]  run_r,   run_nxt;
  logic [FIELD_BITS-1:0]  line_r,  line_nxt;
  logic                   halt_r,  halt_nxt;

  result_t    res0, res1;
  logic [1:0] nres;

  result_t    fifo_r [4];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r;

  logic in_acc, out_acc;

  assign in_stall  = (cnt_r > 3'd2);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign out_acc   = out_valid && !out_stall;

  // token start saturated to the result width
  logic [FIELD_BITS-1:0] start_sat;
  always_comb begin
    if ((start_r >> FIELD_BITS) != '0) begin
      start_sat = FIELD_MAX;
    end else begin
      start_sat = FIELD_BITS'(start_r);
    end
  end

  always_comb begin
    logic    do_bare;
    logic    do_between;
    logic    allow;
    logic [FIELD_BITS-1:0] run_base;
    result_t r;
    do_bare    = 1'b0;
    do_between = 1'b0;
    allow      = in_allow_cross_line;
    run_base   = run_r;
    r          = '0;
    mode_nxt   = mode_r;
    start_nxt  = start_r;
    run_nxt    = run_r;
    line_nxt   = line_r;
    halt_nxt   = halt_r;
    pos_nxt    = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
    res0       = '0;
    res1       = '0;
    nres       = 2'd0;
    r.line_number = line_r;

    unique case (mode_r)
      MODE_SLASH: begin
        if (in_ch == CH_SLASH) begin
          if (!allow) begin
            r.kind   = KIND_INCOMPLETE;
            res0     = r;
            nres     = 2'd1;
            halt_nxt = 1'b1;
            mode_nxt = MODE_SKIP;
          end else begin
            mode_nxt = MODE_COMMENT;
          end
        end else begin
          mode_nxt = MODE_BARE;
          run_base = FIELD_BITS'(1);
          run_nxt  = run_base;
          do_bare  = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (in_ch == CH_NL) begin
          line_nxt = sat_inc(line_r);
          mode_nxt = MODE_SKIP;
        end else if (in_ch == CH_NUL) begin
          r.kind   = allow ? KIND_END : KIND_INCOMPLETE;
          res0     = r;
          nres     = 2'd1;
          halt_nxt = !allow;
          mode_nxt = MODE_SKIP;
        end
      end
      MODE_QUOTED: begin
        if (in_ch == CH_QUOTE) begin
          r.kind         = KIND_TOKEN;
          r.token_start  = start_sat;
          r.token_length = run_r;
          r.quoted       = 1'b1;
          res0           = r;
          nres           = 2'd1;
          mode_nxt       = MODE_SKIP;
        end else if (in_ch == CH_NUL) begin
          r.kind   = KIND_QUOTE_END;
          res0     = r;
          nres     = 2'd1;
          halt_nxt = 1'b1;
          mode_nxt = MODE_SKIP;
        end else begin
          run_nxt = sat_inc(run_r);
        end
      end
      MODE_BARE: begin
        do_bare = 1'b1;
      end
      default: begin
        mode_nxt   = MODE_SKIP;
        do_between = 1'b1;
      end
    endcase

    if (do_bare) begin
      if (in_ch > CH_SPACE) begin
        run_nxt = sat_inc(run_base);
      end else begin
        r              = '0;
        r.line_number  = line_r;
        r.kind         = KIND_TOKEN;
        r.token_start  = start_sat;
        r.token_length = run_base;
        res0           = r;
        nres           = 2'd1;
        mode_nxt       = MODE_SKIP;
        do_between     = 1'b1;
      end
    end

    if (do_between) begin
      r             = '0;
      r.line_number = line_r;
      if (in_ch == CH_NUL) begin
        r.kind   = allow ? KIND_END : KIND_INCOMPLETE;
        halt_nxt = !allow;
        mode_nxt = MODE_SKIP;
        if (nres == 2'd0) begin
          res0 = r;
        end else begin
          res1 = r;
        end
        nres = nres + 2'd1;
      end else if (in_ch <= CH_SPACE) begin
        if (in_ch == CH_NL) begin
          if (!allow) begin
            r.kind   = KIND_INCOMPLETE;
            halt_nxt = 1'b1;
            mode_nxt = MODE_SKIP;
            if (nres == 2'd0) begin
              res0 = r;
            end else begin
              res1 = r;
            end
            nres = nres + 2'd1;
          end else begin
            line_nxt = sat_inc(line_r);
          end
        end
      end else if (in_ch == CH_SLASH) begin
        mode_nxt  = MODE_SLASH;
        start_nxt = pos_r;
      end else if (in_ch == CH_QUOTE) begin
        mode_nxt  = MODE_QUOTED;
        start_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
        run_nxt   = '0;
      end else begin
        mode_nxt  = MODE_BARE;
        start_nxt = pos_r;
        run_nxt   = FIELD_BITS'(1);
      end
    end

    if (nres == 2'd1) begin
      res0.last = 1'b1;
    end else if (nres == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SKIP;
      pos_r   <= '0;
      start_r <= '0;
      run_r   <= '0;
      line_r  <= FIELD_BITS'(1);
      halt_r  <= 1'b0;
    end else if (in_acc && !halt_r) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      run_r   <= run_nxt;
      line_r  <= line_nxt;
      halt_r  <= halt_nxt;
    end
  end

  // result buffer
  logic [1:0] push_n;
  assign push_n = (in_acc && !halt_r) ? nres : 2'd0;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_r + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + push_n;
      rd_r  <= rd_r + {1'b0, out_acc};
      cnt_r <= cnt_r + {1'b0, push_n} - {2'b00, out_acc};
    end
  end

  assign out_kind         = fifo_r[rd_r].kind;
  assign out_token_start  = fifo_r[rd_r].token_start;
  assign out_token_length = fifo_r[rd_r].token_length;
  assign out_quoted       = fifo_r[rd_r].quoted;
  assign out_line_number  = fifo_r[rd_r].line_number;
  assign out_last         = fifo_r[rd_r].last;

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result buffer overflow");

  a_halt_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared without reset");

  a_halt_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> push_n == 2'd0)
    else $error("result pushed while halted");

  a_pair_token_first : assert property (@(posedge clk) disable iff (!rst_n)
    (!halt_r && in_acc && nres == 2'd2) |-> (res0.kind == KIND_TOKEN && res1.kind != KIND_TOKEN))
    else $error("bad result pair");

  a_line_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line count reached zero");

endmodule

// File: tb/script_byte_tokenizer_check.sv
// ----------------------------------------------------------------------------
// script_byte_tokenizer_check
// watches both channels of the tokenizer, keeps its own model of the scanner
// state, works out the token and error results of every accepted byte and
// compares each delivered result field by field against the oldest one due
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module script_byte_tokenizer_check
  import sbt_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_ch,
  input  logic                  in_allow_cross_line,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [1:0]            out_kind,
  input  logic [FIELD_BITS-1:0] out_token_start,
  input  logic [FIELD_BITS-1:0] out_token_length,
  input  logic                  out_quoted,
  input  logic [FIELD_BITS-1:0] out_line_number,
  input  logic                  out_last,
  output int                    fail_count,
  output int                    results_due
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  logic [2:0]             mode;
  logic [OFFSET_BITS-1:0] byte_pos;
  logic [OFFSET_BITS-1:0] body_start;
  logic [FIELD_BITS-1:0]  body_len;
  logic [FIELD_BITS-1:0]  lines;
  logic                   halted;
  int                     errors_seen = 0;

  result_t token_results[$];
  result_t byte_results[$];

  assign fail_count = errors_seen;

  task automatic add_result(input logic [1:0] kind, input logic [OFFSET_BITS-1:0] start,
                            input logic [FIELD_BITS-1:0] len, input logic quoted);
    result_t r;
    if (byte_results.size() < 2) begin
      r.kind         = kind;
      r.token_start  = (start > FIELD_MAX) ? FIELD_MAX : FIELD_BITS'(start);
      r.token_length = len;
      r.quoted       = quoted;
      r.line_number  = lines;
      r.last         = 1'b0;
      byte_results.push_back(r);
    end
  endtask

  task automatic report_error(input logic [1:0] kind);
    add_result(kind, '0, '0, 1'b0);
    halted = 1'b1;
    mode   = MODE_SKIP;
  endtask

  task automatic finish_input(input logic allow);
    if (!allow) report_error(KIND_INCOMPLETE);
    else add_result(KIND_END, '0, '0, 1'b0);
    mode = MODE_SKIP;
  endtask

  // byte seen while no token is open
  task automatic gap_byte(input logic [7:0] b, input logic allow);
    if (b == CH_NUL) begin
      finish_input(allow);
    end else if (b <= CH_SPACE) begin
      if (b == CH_NL) begin
        if (!allow) report_error(KIND_INCOMPLETE);
        else if (lines != FIELD_MAX) lines++;
      end
    end else if (b == CH_SLASH) begin
      mode       = MODE_SLASH;
      body_start = byte_pos;
    end else if (b == CH_QUOTE) begin
      mode       = MODE_QUOTED;
      body_start = (byte_pos != POS_MAX) ? byte_pos + 1'b1 : POS_MAX;
      body_len   = '0;
    end else begin
      mode       = MODE_BARE;
      body_start = byte_pos;
      body_len   = FIELD_BITS'(1);
    end
  endtask

  task automatic bare_byte(input logic [7:0] b, input logic allow);
    if (b > CH_SPACE) begin
      if (body_len != FIELD_MAX) body_len++;
    end else begin
      add_result(KIND_TOKEN, body_start, body_len, 1'b0);
      mode = MODE_SKIP;
      gap_byte(b, allow);
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic allow);
    result_t r;
    if (halted) return;
    byte_results.delete();
    case (mode)
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          if (!allow) report_error(KIND_INCOMPLETE);
          else mode = MODE_COMMENT;
        end else begin
          mode     = MODE_BARE;
          body_len = FIELD_BITS'(1);
          bare_byte(b, allow);
        end
      end
      MODE_COMMENT: begin
        if (b == CH_NL) begin
          if (lines != FIELD_MAX) lines++;
          mode = MODE_SKIP;
        end else if (b == CH_NUL) begin
          finish_input(allow);
        end
      end
      MODE_QUOTED: begin
        if (b == CH_QUOTE) begin
          add_result(KIND_TOKEN, body_start, body_len, 1'b1);
          mode = MODE_SKIP;
        end else if (b == CH_NUL) begin
          report_error(KIND_QUOTE_END);
        end else if (body_len != FIELD_MAX) begin
          body_len++;
        end
      end
      MODE_BARE: bare_byte(b, allow);
      default: begin
        mode = MODE_SKIP;
        gap_byte(b, allow);
      end
    endcase
    if (byte_pos != POS_MAX) byte_pos++;
    foreach (byte_results[i]) begin
      r      = byte_results[i];
      r.last = (i == byte_results.size() - 1);
      token_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors_seen++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      mode       = MODE_SKIP;
      byte_pos   = '0;
      body_start = '0;
      body_len   = '0;
      lines      = FIELD_BITS'(1);
      halted     = 1'b0;
      token_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (token_results.size() == 0) begin
          $error("unexpected result: kind %0d line %0d", out_kind, out_line_number);
          errors_seen++;
        end else begin
          want = token_results.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("token_start", want.token_start, out_token_start);
          check_field("token_length", want.token_length, out_token_length);
          check_field("quoted", want.quoted, out_quoted);
          check_field("line_number", want.line_number, out_line_number);
          check_field("last", want.last, out_last);
        end
      end
      if (in_valid && !in_stall) scan_byte(in_ch, in_allow_cross_line);
    end
    results_due <= token_results.size();
  end

endmodule

// File: tb/script_byte_tokenizer_test.sv
// ----------------------------------------------------------------------------
// script_byte_tokenizer_test
// feeds the tokenizer a short hand-written script, then random well-formed
// scripts with some noise and one closing error; bursty requests and a
// stalling receiver, with results checked by a separate checker module
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module script_byte_tokenizer_test
  import sbt_pkg::*;
;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_ch = 8'h00;
  logic                  in_allow_cross_line = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_kind;
  logic [FIELD_BITS-1:0] out_token_start;
  logic [FIELD_BITS-1:0] out_token_length;
  logic                  out_quoted;
  logic [FIELD_BITS-1:0] out_line_number;
  logic                  out_last;
  int                    fail_count;
  int                    results_due;

  int sent_bytes = 0;
  int burst_left = 0;

  logic [8:0] opening_bytes [0:23];

  always #4 clk = ~clk;

  script_byte_tokenizer i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_ch               (in_ch),
    .in_allow_cross_line (in_allow_cross_line),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_token_start     (out_token_start),
    .out_token_length    (out_token_length),
    .out_quoted          (out_quoted),
    .out_line_number     (out_line_number),
    .out_last            (out_last)
  );

  script_byte_tokenizer_check i_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_ch               (in_ch),
    .in_allow_cross_line (in_allow_cross_line),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_token_start     (out_token_start),
    .out_token_length    (out_token_length),
    .out_quoted          (out_quoted),
    .out_line_number     (out_line_number),
    .out_last            (out_last),
    .fail_count          (fail_count),
    .results_due         (results_due)
  );

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver: changing stall styles, one long hold to back the block up
  initial begin
    int cycle_no;
    int style;
    cycle_no = 0;
    style    = 0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (cycle_no % 128 == 0) style = $urandom_range(0, 3);
      if (cycle_no >= 1200 && cycle_no < 1500) begin
        out_stall <= 1'b1;
      end else begin
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= (cycle_no % 5 < 2);
        endcase
      end
    end
  end

  function automatic bit coin();
    return $urandom_range(0, 1) == 1;
  endfunction

  task automatic push_byte(input logic [7:0] ch, input logic allow);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid            <= 1'b0;
        in_ch               <= 8'($urandom);
        in_allow_cross_line <= coin();
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid            <= 1'b1;
    in_ch               <= ch;
    in_allow_cross_line <= allow;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left != 0) burst_left--;
    sent_bytes++;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic push_blank();
    logic [7:0] ch;
    ch = ($urandom_range(0, 3) == 0) ? CH_NL : 8'($urandom_range(1, 32));
    push_byte(ch, (ch == CH_NL) ? 1'b1 : coin());
  endtask

  // every piece leaves the scanner between tokens
  task automatic send_script_piece();
    logic [7:0] ch;
    logic [7:0] lead;
    int         n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        n    = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        lead = 8'($urandom_range(33, 255));
        if (lead == CH_QUOTE) lead = CH_SLASH;
        push_byte(lead, coin());
        for (int i = 1; i < n; i++) begin
          ch = 8'($urandom_range(33, 255));
          if (i == 1 && lead == CH_SLASH && ch == CH_SLASH) ch = CH_SLASH + 8'd1;
          push_byte(ch, coin());
        end
        if ($urandom_range(0, 7) == 0) push_byte(CH_NUL, 1'b1);
        else push_blank();
      end
      4, 5: begin
        push_byte(CH_QUOTE, coin());
        repeat ($urandom_range(0, 12)) begin
          ch = 8'($urandom_range(1, 255));
          if (ch == CH_QUOTE) ch = CH_NL;
          push_byte(ch, coin());
        end
        push_byte(CH_QUOTE, coin());
      end
      6: begin
        push_byte(CH_SLASH, coin());
        push_byte(CH_SLASH, 1'b1);
        repeat ($urandom_range(0, 10)) begin
          ch = 8'($urandom_range(1, 255));
          if (ch == CH_NL) ch = CH_QUOTE;
          push_byte(ch, coin());
        end
        if ($urandom_range(0, 5) == 0) push_byte(CH_NUL, 1'b1);
        else push_byte(CH_NL, coin());
      end
      7: repeat ($urandom_range(1, 4)) push_blank();
      8: push_byte(CH_NUL, 1'b1);
      default: begin
        repeat ($urandom_range(1, 12)) begin
          ch = 8'($urandom_range(0, 255));
          if (ch == CH_QUOTE) ch = 8'h23;
          push_byte(ch, (ch == CH_NUL || ch == CH_NL || ch == CH_SLASH) ? 1'b1 : coin());
        end
        push_byte(CH_NL, 1'b1);
      end
    endcase
  endtask

  initial begin
    int         start_count;
    bit         paused;

    opening_bytes = '{
      {1'b0, CH_SLASH}, {1'b0, 8'h78}, {1'b1, CH_SPACE},
      {1'b0, CH_SLASH}, {1'b1, CH_SLASH}, {1'b0, 8'h63}, {1'b0, CH_NL},
      {1'b1, CH_QUOTE}, {1'b0, CH_NL}, {1'b0, 8'hFF}, {1'b1, CH_QUOTE},
      {1'b0, 8'h80}, {1'b1, 8'h7F}, {1'b1, CH_NUL},
      {1'b0, 8'h21}, {1'b0, 8'h01},
      {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE},
      {1'b1, CH_SLASH}, {1'b1, CH_NL},
      {1'b1, CH_NUL},
      {1'b0, CH_SLASH}, {1'b1, CH_SLASH}, {1'b1, CH_NUL}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_bytes[i]) push_byte(opening_bytes[i][7:0], opening_bytes[i][8]);
    wait_results_drained();

    start_count = sent_bytes;
    paused      = 1'b0;
    while (sent_bytes - start_count < 1950) begin
      send_script_piece();
      if (!paused && sent_bytes - start_count >= 1600) begin
        wait_results_drained();
        paused = 1'b1;
      end
    end

    repeat (12) send_script_piece();

    // one error halts the block for the rest of the run
    case ($urandom_range(0, 5))
      0: push_byte(CH_NL, 1'b0);
      1: begin
        push_byte(CH_SLASH, 1'b1);
        push_byte(CH_SLASH, 1'b0);
      end
      2: push_byte(CH_NUL, 1'b0);
      3: begin
        push_byte(CH_QUOTE, coin());
        push_byte(8'h41, coin());
        push_byte(CH_NUL, coin());
      end
      4: begin
        push_byte(8'h41, coin());
        push_byte(CH_NL, 1'b0);
      end
      default: begin
        push_byte(CH_SLASH, coin());
        push_byte(CH_SLASH, 1'b1);
        push_byte(8'h41, coin());
        push_byte(CH_NUL, 1'b0);
      end
    endcase
    repeat (8) push_byte(8'($urandom_range(0, 255)), coin());

    wait_results_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sbt_pkg.sv
rtl/script_byte_tokenizer.sv
tb/script_byte_tokenizer_check.sv
tb/script_byte_tokenizer_test.sv
